>>> rtl/triple_box_filter_stream_macros.svh
// Assertion macros used by the checker file of the box filter stream.
`ifndef TRIPLE_BOX_FILTER_STREAM_MACROS_SVH
`define TRIPLE_BOX_FILTER_STREAM_MACROS_SVH

// Check a property at each rising edge, skipped while reset is asserted.
`define TBF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at each rising edge, reset included.
`define TBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/tbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbf_pkg;

	localparam int SAMPLE_W = 16;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Output clamp limits
	localparam sample_t SAT_MAX = 16'sh7fff;
	localparam sample_t SAT_MIN = 16'sh8000;

endpackage

`default_nettype wire

>>> rtl/tbf_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module tbf_ring #(
	parameter int RADIUS = 3,
	localparam int W = 2 * RADIUS + 1,
	localparam int AW = $clog2(W),
	localparam int T3W = tbf_pkg::SAMPLE_W + 3 * AW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tbf_pkg::sample_t      sample,
	input  logic                  start_line,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [T3W-1:0] total_out
);
	import tbf_pkg::*;

	localparam int R1W = SAMPLE_W;
	localparam int R2W = SAMPLE_W + AW;
	localparam int R3W = SAMPLE_W + 2 * AW;
	localparam logic [AW-1:0] LAST_SLOT = AW'(W - 1);

	// One memory word holds the same slot of all three rings
	typedef struct packed {
		logic signed [R3W-1:0] r3;
		logic signed [R2W-1:0] r2;
		logic signed [R1W-1:0] r1;
	} entry_t;

	entry_t                mem_q [W];
	entry_t                rd_data_s1;
	entry_t                old_entry;
	entry_t                new_entry;
	logic [AW-1:0]         slot_q;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         addr_s1;
	logic [W-1:0]          filled_q;
	logic                  v_s1;
	logic                  start_s1;
	sample_t               sample_s1;
	logic                  v_out_q;
	logic                  accept;
	logic                  fire;
	logic signed [R2W-1:0] t1_q;
	logic signed [R3W-1:0] t2_q;
	logic signed [T3W-1:0] t3_q;
	logic signed [R2W-1:0] base1;
	logic signed [R3W-1:0] base2;
	logic signed [T3W-1:0] base3;
	logic signed [R2W-1:0] t1_n;
	logic signed [R3W-1:0] t2_n;
	logic signed [T3W-1:0] t3_n;

	// Handshake: stage one retires when the sum register is free or draining
	assign accept    = in_valid && in_ready;
	assign fire      = v_s1 && (!v_out_q || out_ready);
	assign in_ready  = !v_s1 || fire;
	assign out_valid = v_out_q;
	assign total_out = t3_q;

	// A line start restarts at slot zero
	assign rd_addr = start_line ? '0 : slot_q;

	// Advance the write position per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (accept) begin
			slot_q <= (rd_addr == LAST_SLOT) ? '0 : rd_addr + AW'(1);
		end
	end

	// Stage one valid and item payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			start_s1  <= start_line;
			addr_s1   <= rd_addr;
		end
	end

	// Ring memory: read at transfer, write back when stage one retires
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
		if (fire) begin
			mem_q[addr_s1] <= new_entry;
		end
	end

	// Entries not written since reset or line start read as zero
	always_comb begin
		if (filled_q[addr_s1] && !start_s1) begin
			old_entry = rd_data_s1;
		end else begin
			old_entry = '0;
		end
		base1 = start_s1 ? '0 : t1_q;
		base2 = start_s1 ? '0 : t2_q;
		base3 = start_s1 ? '0 : t3_q;
		t1_n = base1 + R2W'(sample_s1) - R2W'(old_entry.r1);
		t2_n = base2 + R3W'(t1_n) - R3W'(old_entry.r2);
		t3_n = base3 + T3W'(t2_n) - T3W'(old_entry.r3);
		new_entry.r1 = sample_s1;
		new_entry.r2 = t1_n;
		new_entry.r3 = t2_n;
	end

	// Running sums, fill marks and the result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q     <= '0;
			t2_q     <= '0;
			t3_q     <= '0;
			filled_q <= '0;
			v_out_q  <= 1'b0;
		end else begin
			if (fire) begin
				t1_q     <= t1_n;
				t2_q     <= t2_n;
				t3_q     <= t3_n;
				filled_q <= (start_s1 ? '0 : filled_q) | (W'(1) << addr_s1);
				v_out_q  <= 1'b1;
			end else if (out_ready) begin
				v_out_q  <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/tbf_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tbf_div #(
	parameter int RADIUS = 3,
	localparam int W = 2 * RADIUS + 1,
	localparam int AW = $clog2(W),
	localparam int T3W = tbf_pkg::SAMPLE_W + 3 * AW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [T3W-1:0] total,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tbf_pkg::sample_t      smoothed
);
	import tbf_pkg::*;

	localparam int NW = T3W;
	localparam int QW = SAMPLE_W + 1;
	localparam int DEN = W * W * W;
	localparam int HALF = (DEN - 1) / 2;
	localparam logic [63:0] RECIP_FULL = (64'd1 << NW) / 64'(DEN);
	localparam logic [NW-1:0] RECIP = RECIP_FULL[NW-1:0];
	localparam logic [QW-1:0] NEG_LIMIT = QW'(2 ** (SAMPLE_W - 1));
	localparam logic [QW-1:0] POS_LIMIT = NEG_LIMIT - QW'(1);

	logic            v_s1, v_s2, v_s3, v_out_q;
	logic            en1, en2, en3, en_out;
	logic [NW-1:0]   mag;
	logic [NW-1:0]   n_s1, n_s2, n_s3;
	logic            neg_s1, neg_s2, neg_s3;
	logic [2*NW-1:0] prod_s2;
	logic [NW-1:0]   q0_full;
	logic [QW-1:0]   q0_s3;
	logic [NW-1:0]   q0d_s3;
	logic            bump;
	logic [QW-1:0]   q;
	logic [QW-1:0]   q_neg;
	sample_t         res;
	sample_t         smoothed_q;

	// Stage enables: a stage moves when the next one is empty or moving
	assign en_out    = !v_out_q || out_ready;
	assign en3       = !v_s3 || en_out;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign in_ready  = en1;
	assign out_valid = v_out_q;
	assign smoothed  = smoothed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en_out) v_out_q <= v_s3;
		end
	end

	// Magnitude plus half the divisor: rounding becomes a floor
	assign mag = total[T3W-1] ? NW'(-total) : NW'(total);

	// Floor of n / DEN by reciprocal, then one correction step
	assign q0_full = prod_s2[2*NW-1:NW];
	assign bump    = ({1'b0, n_s3} >= ({1'b0, q0d_s3} + (NW + 1)'(DEN)));
	assign q       = q0_s3 + QW'(bump);
	assign q_neg   = -q;

	// Restore sign and clamp to the sample range
	always_comb begin
		if (neg_s3) begin
			res = (q > NEG_LIMIT) ? SAT_MIN : signed'(q_neg[SAMPLE_W-1:0]);
		end else begin
			res = (q > POS_LIMIT) ? SAT_MAX : signed'(q[SAMPLE_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			n_s1   <= mag + NW'(HALF);
			neg_s1 <= total[T3W-1];
		end
		if (en2 && v_s1) begin
			prod_s2 <= (2 * NW)'(n_s1) * (2 * NW)'(RECIP);
			n_s2    <= n_s1;
			neg_s2  <= neg_s1;
		end
		if (en3 && v_s2) begin
			q0_s3  <= q0_full[QW-1:0];
			q0d_s3 <= NW'(q0_full[QW-1:0]) * NW'(DEN);
			n_s3   <= n_s2;
			neg_s3 <= neg_s2;
		end
		if (en_out && v_s3) begin
			smoothed_q <= res;
		end
	end

endmodule

`default_nettype wire

>>> rtl/triple_box_filter_stream.sv
`timescale 1ns / 1ps
`default_nettype none

// Triple cascaded box filter on a sample stream.
// Slave channel: s_tdata carries one signed sample, s_tuser[0] marks the
// start of a new line; that sample is taken into freshly cleared filters.
// Master channel: m_tdata carries the smoothed sample, one per input sample,
// in order.
// Throughput: one sample per clock unless the master side stalls. Each transfer
// reads one ring slot in the shared ring memory and writes it back when stage
// one retires, and the three running sums close a loop through that slot.
// Pipeline: ring read, ring update, then three stages of the rounded division
// by the window cubed, and the output register.
// Reset: pipeline empty, sums and write position zero, every ring slot marked
// unwritten so it reads as zero. No clearing pass; the block is ready at once.
// Stall: a held result stays on m_tdata; internal bubbles close up first,
// after that s_tready drops until the master side takes a transfer.
module triple_box_filter_stream #(
	parameter int RADIUS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	input  logic [0:0]  s_tuser,   // [0] start_line
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [15:0] smoothed
);
	import tbf_pkg::*;

	localparam int W = 2 * RADIUS + 1;
	localparam int AW = $clog2(W);
	localparam int T3W = SAMPLE_W + 3 * AW;

	logic                  sum_valid;
	logic                  sum_ready;
	logic signed [T3W-1:0] sum_total;
	sample_t               smoothed;

	// Ring memory and running sums
	tbf_ring #(
		.RADIUS(RADIUS)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.sample    (signed'(s_tdata)),
		.start_line(s_tuser[0]),
		.out_valid (sum_valid),
		.out_ready (sum_ready),
		.total_out (sum_total)
	);

	// Rounded division and clamp
	tbf_div #(
		.RADIUS(RADIUS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sum_valid),
		.in_ready (sum_ready),
		.total    (sum_total),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.smoothed (smoothed)
	);

	assign m_tdata = smoothed;

endmodule

`default_nettype wire

>>> rtl/tbf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "triple_box_filter_stream_macros.svh"

module tbf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// No result is shown while reset is held
	`TBF_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !m_tvalid, "result valid during reset")

	// With the output free or draining, the whole pipe moves and takes input
	`TBF_ASSERT(a_ready_free, clk, arst_n, (!m_tvalid || m_tready) |-> s_tready, "input stalled without cause")

	// A stalled result holds
	`TBF_ASSERT(a_hold_stall, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

endmodule

bind triple_box_filter_stream tbf_checker u_tbf_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import tbf_pkg::*;

	localparam int RADIUS = 3;
	localparam int WINDOW = 2 * RADIUS + 1;
	localparam longint CUBE = WINDOW * WINDOW * WINDOW;
	localparam int SUM1_W = SAMPLE_W + $clog2(WINDOW);
	localparam int SUM2_W = SUM1_W + $clog2(WINDOW);
	localparam int SUM3_W = SUM2_W + $clog2(WINDOW);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 20;

	typedef enum {
		FILL_RANDOM,
		FILL_MAX,
		FILL_MIN,
		FILL_SMALL,
		FILL_SWING
	} fill_kind_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [15:0] sample
	logic [0:0]  s_tuser;   // [0] start_line
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [15:0] smoothed

	// Filter state mirrored in the testbench
	logic signed [SAMPLE_W-1:0] hist_one[WINDOW];
	logic signed [SUM1_W-1:0]   hist_two[WINDOW];
	logic signed [SUM2_W-1:0]   hist_three[WINDOW];
	logic signed [SUM1_W-1:0]   sum_one;
	logic signed [SUM2_W-1:0]   sum_two;
	logic signed [SUM3_W-1:0]   sum_three;
	int                         fill_pos;

	sample_t smoothed_expected[$];
	int      mismatches;
	int      cycles;
	int      samples_sent;
	int      lines_started;
	int      clipped_results;
	int      stall_left;
	bit      idle_off;

	triple_box_filter_stream #(
		.RADIUS(RADIUS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				smoothed_expected.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic void clear_filters();
		for (int i = 0; i < WINDOW; i++) begin
			hist_one[i] = '0;
			hist_two[i] = '0;
			hist_three[i] = '0;
		end
		sum_one = '0;
		sum_two = '0;
		sum_three = '0;
		fill_pos = 0;
	endfunction

	// Run one sample through the three box stages and return the rounded average
	function automatic sample_t predict_smoothed(sample_t x, bit start);
		int     p;
		longint num;
		longint mag;
		longint q;
		if (start)
			clear_filters();
		p = fill_pos;
		sum_one = sum_one + SUM1_W'(x) - SUM1_W'(hist_one[p]);
		hist_one[p] = x;
		sum_two = sum_two + SUM2_W'(sum_one) - SUM2_W'(hist_two[p]);
		hist_two[p] = sum_one;
		sum_three = sum_three + SUM3_W'(sum_two) - SUM3_W'(hist_three[p]);
		hist_three[p] = sum_two;
		fill_pos = (p == WINDOW - 1) ? 0 : p + 1;
		// divide by the window cubed, half away from zero
		num = longint'(sum_three);
		mag = (num < 0) ? -num : num;
		q = (2 * mag + CUBE) / (2 * CUBE);
		if (num < 0)
			q = -q;
		if (q > longint'(SAT_MAX))
			q = longint'(SAT_MAX);
		if (q < longint'(SAT_MIN))
			q = longint'(SAT_MIN);
		return sample_t'(q);
	endfunction

	function automatic int pick_gap();
		int r;
		if (idle_off)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void note_failure(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, what);
	endfunction

	// Send one sample; predict its result once the transfer happens
	task automatic send_sample(input sample_t x, input bit start);
		int      gap;
		sample_t y;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= 16'($urandom);
			s_tuser <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= x;
		s_tuser <= start;
		do
			@(posedge clk);
		while (!s_tready);
		y = predict_smoothed(x, start);
		smoothed_expected.insert(smoothed_expected.size(), y);
		samples_sent++;
		if (start)
			lines_started++;
		if (y == SAT_MAX || y == SAT_MIN)
			clipped_results++;
	endtask

	task automatic release_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Hold until every outstanding result has been taken
	task automatic wait_drained();
		while (smoothed_expected.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic sample_t line_sample(fill_kind_t kind, int idx);
		case (kind)
			FILL_MAX:   return SAT_MAX;
			FILL_MIN:   return SAT_MIN;
			FILL_SMALL: return sample_t'($signed($urandom_range(0, 8)) - 4);
			FILL_SWING: return (idx % 2) ? SAT_MIN : SAT_MAX;
			default:    return sample_t'($urandom);
		endcase
	endfunction

	// Send one line: start flag on the first sample, content of a randomly picked kind
	task automatic send_line(input int len);
		fill_kind_t kind;
		int         r;
		r = $urandom_range(0, 99);
		if (r < 50)
			kind = FILL_RANDOM;
		else if (r < 62)
			kind = FILL_MAX;
		else if (r < 74)
			kind = FILL_MIN;
		else if (r < 88)
			kind = FILL_SMALL;
		else
			kind = FILL_SWING;
		for (int i = 0; i < len; i++)
			send_sample(line_sample(kind, i), i == 0);
	endtask

	function automatic int pick_line_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(40, 80);
		return $urandom_range(1, 30);
	endfunction

	// Compare each result with the oldest prediction
	always @(posedge clk) begin
		sample_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (smoothed_expected.size() == 0) begin
				note_failure($sformatf("unexpected result %0d", $signed(m_tdata)));
			end else begin
				want = smoothed_expected.pop_front();
				if (m_tdata !== want)
					note_failure($sformatf("smoothed: expected %0d, got %0d",
						want, $signed(m_tdata)));
			end
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		int r;
		if (idle_off) begin
			m_tready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				m_tready <= 1'b1;
			end else if (r < 96) begin
				m_tready <= 1'b0;
				stall_left <= $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b0;
				stall_left <= $urandom_range(10, 40);
			end
		end
	end

	// Extremes, warmup from reset, rounding near zero, restart mid-window
	task automatic test_directed();
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd1, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(SAT_MIN, 1'b1);
		repeat (8) send_sample(SAT_MIN, 1'b0);
		send_sample(SAT_MAX, 1'b1);
		repeat (8) send_sample(SAT_MAX, 1'b0);
		send_sample(16'sd5, 1'b1);
		send_sample(-16'sd5, 1'b0);
		send_sample(SAT_MAX, 1'b0);
		send_sample(SAT_MIN, 1'b0);
	endtask

	// Well-formed lines with random content and lengths
	task automatic test_random_lines(input int budget);
		int len;
		while (budget > 0) begin
			len = pick_line_len();
			if (len > budget)
				len = budget;
			send_line(len);
			budget -= len;
		end
	endtask

	// Random samples with the start flag set at random
	task automatic test_noise(input int count);
		for (int i = 0; i < count; i++)
			send_sample(sample_t'($urandom), $urandom_range(0, 3) == 0);
	endtask

	// Back-to-back transfers with both sides always ready
	task automatic test_full_rate(input int count);
		idle_off = 1'b1;
		test_random_lines(count);
		idle_off = 1'b0;
	endtask

	// Stop sending until everything is out, then carry on the same line
	task automatic test_pause_midline();
		send_line(12);
		release_input();
		wait_drained();
		for (int i = 0; i < 12; i++)
			send_sample(sample_t'($urandom), 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		stall_left = 0;
		idle_off = 1'b0;
		mismatches = 0;
		cycles = 0;
		samples_sent = 0;
		lines_started = 0;
		clipped_results = 0;
		clear_filters();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_lines(900);
		test_pause_midline();
		test_noise(150);
		test_full_rate(150);
		test_random_lines(100);
		release_input();
		wait_drained();

		$display("sent %0d samples over %0d line starts; %0d results at the clamp limits",
			samples_sent, lines_started, clipped_results);
		$display("covered warmup from reset, restarts, full rate, random stalls, mid-line pause");
		if (mismatches == 0 && smoothed_expected.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				smoothed_expected.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tbf_pkg.sv
rtl/tbf_ring.sv
rtl/tbf_div.sv
rtl/triple_box_filter_stream.sv
rtl/tbf_checker.sv
tb/testbench.sv
